// File: rtl/oad_pkg.sv
// Shared constants, types and score arithmetic for the overlap alignment block.
package oad_pkg;

  localparam int MAX_LEN = 256;
  localparam int SYM_W   = 8;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int PIDX_W  = $clog2(2 * MAX_LEN);
  localparam int PCNT_W  = 10;
  localparam int SC_W    = 15;
  localparam int CFG_W   = 5;
  localparam int CIDX_W  = 2;
  localparam int BEST_W  = 12;

  localparam logic signed [SC_W-1:0] NEG_INF = {1'b1, {(SC_W-1){1'b0}}};
  localparam logic signed [SC_W:0]   SC_MAX  = {2'b00, {(SC_W-1){1'b1}}};
  localparam logic signed [SC_W:0]   SC_MIN  = {2'b11, {(SC_W-2){1'b0}}, 1'b1};
  localparam logic signed [SC_W-1:0] BEST_MAX = SC_W'((1 << BEST_W) - 1);

  localparam logic [2:0] REQ_APPEND_A = 3'd0;
  localparam logic [2:0] REQ_APPEND_B = 3'd1;
  localparam logic [2:0] REQ_RUN      = 3'd2;
  localparam logic [2:0] REQ_READ     = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;

  localparam logic [1:0] OP_DIAG = 2'd0;
  localparam logic [1:0] OP_LEFT = 2'd1;
  localparam logic [1:0] OP_UP   = 2'd2;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_COLUMN  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NO_COL   = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_MATCH    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MISMATCH = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GAP      = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic clear;
    logic run_start;
    logic row_prep;
    logic fill;
    logic tb_op;
    logic post_run;
    logic post_col;
  } oad_cmd_t;

  typedef struct packed {
    logic empty;
    logic row_end;
    logic last_row;
    logic tb_end;
    logic out_free;
  } oad_stat_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ROW_PREP = 7'b0000010,
    S_CELL     = 7'b0000100,
    S_TB_RD    = 7'b0001000,
    S_TB_OP    = 7'b0010000,
    S_POST_RUN = 7'b0100000,
    S_POST_COL = 7'b1000000
  } oad_state_t;

  // Saturating add; minus infinity stays minus infinity.
  function automatic logic signed [SC_W-1:0] add_sc(input logic signed [SC_W-1:0] x,
                                                      input logic signed [CFG_W-1:0] d);
    logic signed [SC_W:0] s;
    s = {x[SC_W-1], x} + {{(SC_W+1-CFG_W){d[CFG_W-1]}}, d};
    if (x == NEG_INF) begin
      return NEG_INF;
    end else if (s > SC_MAX) begin
      return SC_MAX[SC_W-1:0];
    end else if (s < SC_MIN) begin
      return SC_MIN[SC_W-1:0];
    end
    return s[SC_W-1:0];
  endfunction

endpackage

// File: rtl/oad_if.sv
// Valid/ready channel interfaces for requests and results.
interface oad_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] symbol;
  modport source (output valid, req_type, symbol, input ready);
  modport sink (input valid, req_type, symbol, output ready);
endinterface

interface oad_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  status;
  logic [11:0] best_score;
  logic [9:0]  path_length;
  logic [7:0]  a_symbol;
  logic [7:0]  b_symbol;
  logic        a_gap;
  logic        b_gap;
  logic        last_column;
  modport source (output valid, result_kind, status, best_score, path_length, a_symbol,
                  b_symbol, a_gap, b_gap, last_column, input ready);
  modport sink (input valid, result_kind, status, best_score, path_length, a_symbol,
                b_symbol, a_gap, b_gap, last_column, output ready);
endinterface

// File: rtl/overlap_alignment_dp.sv
// Overlap alignment engine with linear gap score: top level.
// Appends and clear are accepted in the idle state; a column read posts once the output register is free.
// A run with both sequences non-empty fills the matrix row by row (a row setup state, then one cell
// per cycle), then traceback read and op states in turn, a closing check, and the summary post.
// One item is in work at a time; a result waits in an output register while loads go on.
// Synchronous active-low reset clears lengths, flags, path state and scores to defaults.
module overlap_alignment_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  oad_in_if.sink                     in_chan,
  oad_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [oad_pkg::CIDX_W-1:0] cfg_index,
  input  logic [oad_pkg::CFG_W-1:0]  cfg_wdata
);
  import oad_pkg::*;

  oad_cmd_t  cmd;
  oad_stat_t stat;

  oad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_req   (in_chan.req_type),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  oad_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_symbol (in_chan.symbol),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_chan  (out_chan)
  );

endmodule

// File: rtl/oad_ctrl.sv
// Sequencer for loads, matrix fill, traceback and result posting.
module oad_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_req,
  output logic               in_ready,
  input  oad_pkg::oad_stat_t stat,
  output oad_pkg::oad_cmd_t  cmd
);
  import oad_pkg::*;

  oad_state_t state_r, state_nxt;
  logic       take;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_ready && in_valid;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.row_prep  = (state_r == S_ROW_PREP);
    cmd.fill      = (state_r == S_CELL);
    cmd.tb_op     = (state_r == S_TB_OP);
    cmd.post_run  = (state_r == S_POST_RUN);
    cmd.post_col  = (state_r == S_POST_COL);
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (in_req)
            REQ_APPEND_A: cmd.load_a = 1'b1;
            REQ_APPEND_B: cmd.load_b = 1'b1;
            REQ_CLEAR:    cmd.clear = 1'b1;
            REQ_RUN: begin
              cmd.run_start = 1'b1;
              state_nxt = stat.empty ? S_TB_RD : S_ROW_PREP;
            end
            REQ_READ:     state_nxt = S_POST_COL;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_ROW_PREP: state_nxt = S_CELL;
      S_CELL: begin
        if (stat.row_end) begin
          state_nxt = stat.last_row ? S_TB_RD : S_ROW_PREP;
        end
      end
      S_TB_RD:    state_nxt = stat.tb_end ? S_POST_RUN : S_TB_OP;
      S_TB_OP:    state_nxt = S_TB_RD;
      S_POST_RUN: if (stat.out_free) state_nxt = S_IDLE;
      S_POST_COL: if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/oad_dp.sv
// Datapath: sequence stores, score row, pointer matrix, path and result register.
module oad_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  oad_pkg::oad_cmd_t         cmd,
  output oad_pkg::oad_stat_t        stat,
  input  logic [oad_pkg::SYM_W-1:0] in_symbol,
  input  logic                      cfg_we,
  input  logic [oad_pkg::CIDX_W-1:0] cfg_index,
  input  logic [oad_pkg::CFG_W-1:0] cfg_wdata,
  oad_out_if.source                 out_chan
);
  import oad_pkg::*;

  logic [SYM_W-1:0]  a_mem [MAX_LEN];
  logic [SYM_W-1:0]  b_mem [MAX_LEN];
  logic [SC_W-1:0]   row_mem [MAX_LEN];
  logic [1:0]        ptr_mem [MAX_LEN*MAX_LEN];
  logic [1:0]        path_mem [2*MAX_LEN];

  logic signed [CFG_W-1:0] match_r, mismatch_r, gap_r;
  logic [LEN_W-1:0]  len_a_r, len_b_r, i_r, j_r, jbest_r, a_pos_r, b_pos_r;
  logic              ovf_r;
  logic [PCNT_W-1:0] path_cnt_r, cursor_r, m_r;
  logic signed [SC_W-1:0] best_r, left_r, diag_r;

  logic [SYM_W-1:0]  a_rd_r, b_rd_r;
  logic [SC_W-1:0]   row_rd_r;
  logic [1:0]        ptr_rd_r, path_rd_r;

  logic [LEN_W-1:0]  im1, jm1;
  logic [IDX_W-1:0]  a_ra, b_ra, row_ra;
  logic [PCNT_W-1:0] path_ra;
  logic signed [SC_W-1:0] up, c_left, c_diag, c_up, v_nxt;
  logic signed [CFG_W-1:0] pair_sc;
  logic [1:0]        p_nxt, tb_p;
  logic              new_best;
  logic              col_ok, a_used, b_used;

  assign im1 = i_r - LEN_W'(1);
  assign jm1 = j_r - LEN_W'(1);

  // Read addresses: matrix fill during a run, read positions otherwise.
  assign a_ra    = (cmd.row_prep || cmd.fill) ? im1[IDX_W-1:0] : a_pos_r[IDX_W-1:0];
  assign row_ra  = cmd.row_prep ? '0 : j_r[IDX_W-1:0];
  assign b_ra    = cmd.row_prep ? '0 : (cmd.fill ? j_r[IDX_W-1:0] : b_pos_r[IDX_W-1:0]);
  assign path_ra = path_cnt_r - PCNT_W'(1) - cursor_r;

  always_comb begin
    up      = (i_r == LEN_W'(1)) ? NEG_INF : $signed(row_rd_r);
    pair_sc = (a_rd_r == b_rd_r) ? match_r : mismatch_r;
    c_left  = add_sc(left_r, gap_r);
    c_diag  = add_sc(diag_r, pair_sc);
    c_up    = add_sc(up, gap_r);
    v_nxt   = c_left;
    p_nxt   = OP_LEFT;
    if (c_diag > v_nxt) begin
      v_nxt = c_diag;
      p_nxt = OP_DIAG;
    end
    if (c_up > v_nxt) begin
      v_nxt = c_up;
      p_nxt = OP_UP;
    end
    new_best = (i_r == len_a_r) && (v_nxt > best_r);
  end

  always_comb begin
    tb_p = (i_r == '0) ? OP_LEFT : ptr_rd_r;
    if (tb_p != OP_DIAG && tb_p != OP_UP) begin
      tb_p = OP_LEFT;
    end
  end

  assign col_ok = (cursor_r < path_cnt_r);
  assign a_used = (path_rd_r == OP_DIAG) || (path_rd_r == OP_UP);
  assign b_used = (path_rd_r == OP_DIAG) || (path_rd_r == OP_LEFT);

  assign stat.empty    = (len_a_r == '0) || (len_b_r == '0);
  assign stat.row_end  = (j_r == len_b_r);
  assign stat.last_row = (i_r == len_a_r);
  assign stat.tb_end   = (j_r == '0);
  assign stat.out_free = !out_chan.valid || out_chan.ready;

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.load_a && (len_a_r < LEN_W'(MAX_LEN))) begin
      a_mem[len_a_r[IDX_W-1:0]] <= in_symbol;
    end
    if (cmd.load_b && (len_b_r < LEN_W'(MAX_LEN))) begin
      b_mem[len_b_r[IDX_W-1:0]] <= in_symbol;
    end
    if (cmd.fill) begin
      row_mem[jm1[IDX_W-1:0]] <= v_nxt;
      ptr_mem[{im1[IDX_W-1:0], jm1[IDX_W-1:0]}] <= p_nxt;
    end
    if (cmd.tb_op) begin
      path_mem[m_r[PIDX_W-1:0]] <= tb_p;
    end
    a_rd_r    <= a_mem[a_ra];
    b_rd_r    <= b_mem[b_ra];
    row_rd_r  <= row_mem[row_ra];
    ptr_rd_r  <= ptr_mem[{im1[IDX_W-1:0], jm1[IDX_W-1:0]}];
    path_rd_r <= path_mem[path_ra[PIDX_W-1:0]];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= CFG_W'(1);
      mismatch_r <= -CFG_W'(2);
      gap_r      <= -CFG_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH:    match_r <= cfg_wdata;
        CFG_MISMATCH: mismatch_r <= cfg_wdata;
        CFG_GAP:      gap_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Control and position state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r    <= '0;
      len_b_r    <= '0;
      ovf_r      <= 1'b0;
      path_cnt_r <= '0;
      cursor_r   <= '0;
      a_pos_r    <= '0;
      b_pos_r    <= '0;
      i_r        <= '0;
      j_r        <= '0;
      m_r        <= '0;
      jbest_r    <= '0;
      best_r     <= '0;
    end else begin
      if (cmd.load_a) begin
        if (len_a_r < LEN_W'(MAX_LEN)) len_a_r <= len_a_r + LEN_W'(1);
        else ovf_r <= 1'b1;
      end
      if (cmd.load_b) begin
        if (len_b_r < LEN_W'(MAX_LEN)) len_b_r <= len_b_r + LEN_W'(1);
        else ovf_r <= 1'b1;
      end
      if (cmd.clear) begin
        len_a_r    <= '0;
        len_b_r    <= '0;
        ovf_r      <= 1'b0;
        path_cnt_r <= '0;
        cursor_r   <= '0;
        a_pos_r    <= '0;
        b_pos_r    <= '0;
      end
      if (cmd.run_start) begin
        i_r     <= stat.empty ? len_a_r : LEN_W'(1);
        j_r     <= '0;
        m_r     <= '0;
        best_r  <= '0;
        jbest_r <= '0;
      end
      if (cmd.row_prep) begin
        j_r <= LEN_W'(1);
      end
      if (cmd.fill) begin
        if (new_best) begin
          best_r  <= v_nxt;
          jbest_r <= j_r;
        end
        if (stat.row_end) begin
          if (stat.last_row) j_r <= new_best ? j_r : jbest_r;
          else i_r <= i_r + LEN_W'(1);
        end else begin
          j_r <= j_r + LEN_W'(1);
        end
      end
      if (cmd.tb_op) begin
        m_r <= m_r + PCNT_W'(1);
        if (tb_p == OP_DIAG || tb_p == OP_UP) i_r <= im1;
        if (tb_p == OP_DIAG || tb_p == OP_LEFT) j_r <= jm1;
      end
      if (cmd.post_run && stat.out_free) begin
        path_cnt_r <= m_r;
        cursor_r   <= '0;
        a_pos_r    <= i_r;
        b_pos_r    <= '0;
      end
      if (cmd.post_col && stat.out_free && col_ok) begin
        cursor_r <= cursor_r + PCNT_W'(1);
        if (a_used) a_pos_r <= a_pos_r + LEN_W'(1);
        if (b_used) b_pos_r <= b_pos_r + LEN_W'(1);
      end
    end
  end

  // Left and diagonal neighbors of the cell being filled.
  always_ff @(posedge clk) begin
    if (cmd.row_prep) begin
      left_r <= '0;
      diag_r <= '0;
    end else if (cmd.fill) begin
      left_r <= v_nxt;
      diag_r <= up;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_chan.valid <= 1'b0;
    end else if ((cmd.post_run || cmd.post_col) && stat.out_free) begin
      out_chan.valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_chan.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post_run && stat.out_free) begin
      out_chan.result_kind <= KIND_SUMMARY;
      out_chan.status      <= ovf_r ? ST_OVERFLOW : ST_OK;
      out_chan.best_score  <= (best_r < 0) ? '0 :
                              (best_r > BEST_MAX) ? BEST_MAX[BEST_W-1:0] : best_r[BEST_W-1:0];
      out_chan.path_length <= m_r;
      out_chan.a_symbol    <= '0;
      out_chan.b_symbol    <= '0;
      out_chan.a_gap       <= 1'b0;
      out_chan.b_gap       <= 1'b0;
      out_chan.last_column <= 1'b0;
    end else if (cmd.post_col && stat.out_free) begin
      out_chan.result_kind <= KIND_COLUMN;
      out_chan.status      <= col_ok ? ST_OK : ST_NO_COL;
      out_chan.best_score  <= '0;
      out_chan.path_length <= '0;
      out_chan.a_symbol    <= (col_ok && a_used) ? a_rd_r : '0;
      out_chan.b_symbol    <= (col_ok && b_used) ? b_rd_r : '0;
      out_chan.a_gap       <= col_ok && !a_used;
      out_chan.b_gap       <= col_ok && !b_used;
      out_chan.last_column <= col_ok && (cursor_r + PCNT_W'(1) == path_cnt_r);
    end
  end

endmodule

// File: rtl/oad_checker.sv
// Port-level checks on the result channel, bound to the top level.
module oad_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [1:0]  status,
  input logic        a_gap,
  input logic        b_gap,
  input logic        last_column,
  input logic [11:0] best_score
);
  import oad_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(best_score) && $stable(status))
    else $error("result changed while stalled");

  a_gaps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_COLUMN && status == ST_OK |-> !(a_gap && b_gap))
    else $error("column with two gaps");

  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_SUMMARY |-> !a_gap && !b_gap && !last_column)
    else $error("summary carries column marks");

  a_nocol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_NO_COL |-> result_kind == KIND_COLUMN && !last_column)
    else $error("bad empty-column result");

endmodule

bind overlap_alignment_dp oad_assertions u_oad_assertions (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .result_kind (out_chan.result_kind),
  .status      (out_chan.status),
  .a_gap       (out_chan.a_gap),
  .b_gap       (out_chan.b_gap),
  .last_column (out_chan.last_column),
  .best_score  (out_chan.best_score)
);
